FILE: hdl/srtc_pkg.sv
// Shared types and constants of the serial real-time clock.
package srtc_pkg;

  // Parameter RAM size and address width
  localparam int unsigned PramBytes = 256;
  localparam int unsigned PramAw    = $clog2(PramBytes);

  // Command byte decoding
  localparam logic [7:0] ExtMask    = 8'h78;
  localparam logic [7:0] ExtMatch   = 8'h38;
  localparam logic [4:0] TPramLow   = 5'd8;   // first legacy PRAM target
  localparam logic [4:0] TTest      = 5'd12;  // test register
  localparam logic [4:0] TWrProt    = 5'd13;  // write-protect register
  localparam logic [4:0] TPramHigh  = 5'd16;  // first upper PRAM target
  localparam logic [3:0] PramHiBase = 4'h1;   // upper targets land at 0x10
  localparam logic [5:0] PramLoBase = 6'h02;  // legacy targets land at 0x08

  // Input kind codes
  localparam logic [1:0] KindEdge   = 2'd0;
  localparam logic [1:0] KindSelect = 2'd1;
  localparam logic [1:0] KindTick   = 2'd2;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_EDGE,
    OP_DESELECT,
    OP_TICK
  } srtc_op_e;

  // Transfer phase of the serial protocol
  typedef enum logic [1:0] {
    PH_CMD,
    PH_DATA,
    PH_EXT_ADDR,
    PH_EXT_DATA
  } srtc_phase_e;

  // One queued request
  typedef struct packed {
    srtc_op_e    op;
    logic        data_in;
    logic [31:0] seconds_delta;
  } srtc_item_t;

  // One result
  typedef struct packed {
    logic [31:0] seconds_count;
    logic        write_protected;
    logic        data_bit;
    logic        drives_line;
  } srtc_result_t;

endpackage

FILE: hdl/serial_rtc_with_param_ram.sv
// Serial real-time clock: an accepted request passes through the request queue and
// then the result register before its result appears.
// Throughput: one request per cycle while no side stalls; the result register
// and the request queue let both stream sides stall independently.
// A parameter RAM read lands in a registered read port in the cycle after the
// command byte; the next serial edge takes its bit from there.
// Reset: asynchronous, active low; parameter RAM reads zero until written.
module serial_rtc_with_param_ram
  import srtc_pkg::*;
#(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // chip_disabled, data_in, seconds_delta[31:0]
  input  logic [1:0]  s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // drives_line, data_bit, write_protected,
                                       // seconds_count[31:0]
);

  srtc_item_t   front_item, queue_item;
  srtc_result_t res;
  logic         q_full, q_empty, q_pop;

  assign s_axis_tready_o = !q_full;

  srtc_front u_front (
    .kind_i          (s_axis_tuser_i),
    .chip_disabled_i (s_axis_tdata_i[0]),
    .data_in_i       (s_axis_tdata_i[1]),
    .seconds_delta_i (s_axis_tdata_i[33:2]),
    .item_o          (front_item)
  );

  srtc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (queue_item),
    .empty_o     (q_empty)
  );

  srtc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_empty),
    .item_i       (queue_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_o        (res),
    .res_ready_i  (m_axis_tready_i)
  );

  // Pack the result, first field lowest
  assign m_axis_tdata_o = {5'b00000, res.seconds_count, res.write_protected,
                           res.data_bit, res.drives_line};

endmodule

FILE: hdl/srtc_front.sv
// Front end: accepts requests and classifies them into operations.
module srtc_front
  import srtc_pkg::*;
(
  input  logic [1:0]  kind_i,
  input  logic        chip_disabled_i,
  input  logic        data_in_i,
  input  logic [31:0] seconds_delta_i,
  output srtc_item_t  item_o
);

  // Drop edges while deselected and enable events; keep ticks
  always_comb begin
    item_o.data_in       = data_in_i;
    item_o.seconds_delta = seconds_delta_i;
    unique case (kind_i)
      KindEdge:   item_o.op = chip_disabled_i ? OP_NONE : OP_EDGE;
      KindSelect: item_o.op = chip_disabled_i ? OP_DESELECT : OP_NONE;
      KindTick:   item_o.op = OP_TICK;
      default:    item_o.op = OP_NONE;
    endcase
  end

endmodule

FILE: hdl/srtc_fifo.sv
// Short queue between the classifying front end and the back end.
module srtc_fifo
  import srtc_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  srtc_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output srtc_item_t pop_item_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  srtc_item_t            store_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o     = (count_q == CntFull);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = store_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntFull)
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (empty_o && !push_i) |=> empty_o)
    else $error("queue filled without a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (do_push && !do_pop) |=> !empty_o)
    else $error("queue empty after a push");

endmodule

FILE: hdl/srtc_core.sv
// Back end: serial protocol, seconds counter, parameter RAM and result register.
module srtc_core
  import srtc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  srtc_item_t   item_i,
  output logic         item_pop_o,
  output logic         res_valid_o,
  output srtc_result_t res_o,
  input  logic         res_ready_i
);

  // Protocol state
  logic [7:0]     shift_q, shift_d;
  logic [2:0]     bc_q, bc_d;
  srtc_phase_e    phase_q, phase_d;
  logic [7:0]     cmd_q, cmd_d;
  logic [7:0]     ext_q, ext_d;
  logic           prot_q, prot_d;
  logic           drv_next_q, drv_next_d;
  logic [31:0]    sec_q, sec_d;
  logic           pend_q, pend_d;   // shift register value waits in RAM read data

  // Parameter RAM
  logic [7:0]        pram [PramBytes];
  logic [PramBytes-1:0] pvalid_q;
  logic [7:0]        rdata_q;
  logic              rvalid_q;
  logic              mem_re, mem_we;
  logic [PramAw-1:0] mem_ra, mem_wa;
  logic [7:0]        mem_wd;

  // Result register
  logic         out_valid_q;
  srtc_result_t out_q, res_d;

  logic         fire;
  logic [7:0]   sh, ns;
  logic [4:0]   t;
  logic         drives, dbit;

  assign item_pop_o  = item_valid_i && (!out_valid_q || res_ready_i);
  assign fire        = item_pop_o;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Current shift value, taking a pending RAM read into account
  assign sh = pend_q ? (rvalid_q ? rdata_q : 8'h00) : shift_q;
  assign ns = {sh[6:0], item_i.data_in};

  // Execute one operation
  always_comb begin
    shift_d    = sh;
    bc_d       = bc_q;
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    ext_d      = ext_q;
    prot_d     = prot_q;
    drv_next_d = drv_next_q;
    sec_d      = sec_q;
    pend_d     = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = '0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = ns;
    drives     = 1'b0;
    dbit       = 1'b0;
    t          = 5'd0;
    unique case (item_i.op)
      OP_EDGE: begin
        bc_d = bc_q - 1'b1;
        if (drv_next_q) begin
          // Shift out, most significant bit first
          drives = 1'b1;
          dbit   = sh[bc_d];
          if (bc_d == 3'd0) begin
            drv_next_d = 1'b0;
          end
        end else begin
          shift_d = ns;
          if (bc_d == 3'd0) begin
            unique case (phase_q)
              PH_CMD: begin
                t = ns[6:2];
                if ((ns & ExtMask) == ExtMatch) begin
                  cmd_d   = ns;
                  phase_d = PH_EXT_ADDR;
                end else if (ns[7]) begin
                  drv_next_d = 1'b1;
                  if (t < TPramLow) begin
                    shift_d = sec_q[{t[1:0], 3'b000} +: 8];
                  end else if (t < TTest) begin
                    mem_re = 1'b1;
                    mem_ra = {PramLoBase, t[1:0]};
                    pend_d = 1'b1;
                  end else if (t < TPramHigh) begin
                    shift_d = 8'h00;
                  end else begin
                    mem_re = 1'b1;
                    mem_ra = {PramHiBase, t[3:0]};
                    pend_d = 1'b1;
                  end
                end else begin
                  cmd_d   = ns;
                  phase_d = PH_DATA;
                end
              end
              PH_DATA: begin
                t       = cmd_q[6:2];
                phase_d = PH_CMD;
                if (t < TPramLow) begin
                  if (!prot_q) begin
                    sec_d[{t[1:0], 3'b000} +: 8] = ns;
                  end
                end else if (t < TTest) begin
                  mem_we = !prot_q;
                  mem_wa = {PramLoBase, t[1:0]};
                end else if (t < TPramHigh) begin
                  if (t == TWrProt) begin
                    prot_d = ns[7];
                  end
                end else begin
                  mem_we = !prot_q;
                  mem_wa = {PramHiBase, t[3:0]};
                end
              end
              PH_EXT_ADDR: begin
                ext_d = {cmd_q[2:0], ns[6:2]};
                if (cmd_q[7]) begin
                  mem_re     = 1'b1;
                  mem_ra     = {cmd_q[2:0], ns[6:2]};
                  pend_d     = 1'b1;
                  drv_next_d = 1'b1;
                  phase_d    = PH_CMD;
                end else begin
                  phase_d = PH_EXT_DATA;
                end
              end
              default: begin
                mem_we  = !prot_q;
                mem_wa  = ext_q;
                phase_d = PH_CMD;
              end
            endcase
          end
        end
      end
      OP_DESELECT: begin
        // Abort any transfer
        phase_d    = PH_CMD;
        drv_next_d = 1'b0;
        shift_d    = 8'h00;
        bc_d       = 3'd0;
      end
      OP_TICK: begin
        sec_d = sec_q + item_i.seconds_delta;
      end
      default: begin
        pend_d = pend_q;
      end
    endcase
    res_d.drives_line     = drives;
    res_d.data_bit        = dbit;
    res_d.write_protected = prot_d;
    res_d.seconds_count   = sec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= 8'h00;
      bc_q        <= 3'd0;
      phase_q     <= PH_CMD;
      cmd_q       <= 8'h00;
      ext_q       <= 8'h00;
      prot_q      <= 1'b0;
      drv_next_q  <= 1'b0;
      sec_q       <= '0;
      pend_q      <= 1'b0;
      pvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        shift_q    <= shift_d;
        bc_q       <= bc_d;
        phase_q    <= phase_d;
        cmd_q      <= cmd_d;
        ext_q      <= ext_d;
        prot_q     <= prot_d;
        drv_next_q <= drv_next_d;
        sec_q      <= sec_d;
        pend_q     <= pend_d;
        if (mem_we) begin
          pvalid_q[mem_wa] <= 1'b1;
        end
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  // Parameter RAM write and registered read
  always_ff @(posedge clk_i) begin
    if (fire && mem_we) begin
      pram[mem_wa] <= mem_wd;
    end
    if (fire && mem_re) begin
      rdata_q  <= pram[mem_ra];
      rvalid_q <= pvalid_q[mem_ra];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> drv_next_q)
    else $error("pending RAM read without a read transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (phase_q != PH_CMD) |-> !drv_next_q)
    else $error("driving while a write or extended command is open");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (fire && item_i.op == OP_DESELECT) |=>
      (phase_q == PH_CMD && !drv_next_q && bc_q == 3'd0 && !pend_q))
    else $error("deselect did not abort the transfer");

endmodule

FILE: tb/srtc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the serial clock: predicts every result and checks the output stream.
module srtc_checker
  import srtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [39:0] req_data_i,  // chip_disabled, data_in, seconds_delta[31:0]
  input  logic [1:0]  req_user_i,  // kind
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [39:0] rsp_data_i,  // drives_line, data_bit, write_protected,
                                   // seconds_count[31:0]
  input  logic        flush_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Shadow copy of the clock's serial engine and storage
  logic [7:0]   shift_q;
  logic [2:0]   bit_cnt;
  srtc_phase_e  xfer_phase;
  logic [7:0]   held_cmd;
  logic [7:0]   ext_addr;
  logic         wp_flag;
  logic         out_now;
  logic         out_next;
  logic [31:0]  secs;
  logic [7:0]   pram [PramBytes];

  // Results still owed by the block, oldest first
  srtc_result_t owed_results[$];

  task automatic report(input string msg);
    fail_count_o++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Register read selected by bits 6..2 of a command
  function automatic logic [7:0] reg_read(input logic [7:0] cmd);
    logic [4:0] tgt;
    tgt = cmd[6:2];
    if (tgt < TPramLow) return secs[tgt[1:0]*8 +: 8];
    if (tgt < TTest) return pram[{PramLoBase, tgt[1:0]}];
    if (tgt < TPramHigh) return 8'd0;
    return pram[{PramHiBase, tgt[3:0]}];
  endfunction

  // Register write; protection drops seconds and RAM writes only
  task automatic reg_write(input logic [7:0] cmd, input logic [7:0] wdata);
    logic [4:0] tgt;
    tgt = cmd[6:2];
    if (tgt < TPramLow) begin
      if (!wp_flag) secs[tgt[1:0]*8 +: 8] = wdata;
    end else if (tgt < TTest) begin
      if (!wp_flag) pram[{PramLoBase, tgt[1:0]}] = wdata;
    end else if (tgt == TWrProt) begin
      wp_flag = wdata[7];
    end else if (tgt >= TPramHigh) begin
      if (!wp_flag) pram[{PramHiBase, tgt[3:0]}] = wdata;
    end
  endtask

  // Act on a completed byte according to the transfer phase
  task automatic finish_byte();
    case (xfer_phase)
      PH_CMD: begin
        if ((shift_q & ExtMask) == ExtMatch) begin
          held_cmd   = shift_q;
          xfer_phase = PH_EXT_ADDR;
        end else if (shift_q[7]) begin
          shift_q  = reg_read(shift_q);
          out_next = 1'b1;
        end else begin
          held_cmd   = shift_q;
          xfer_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        reg_write(held_cmd, shift_q);
        xfer_phase = PH_CMD;
      end
      PH_EXT_ADDR: begin
        ext_addr = {held_cmd[2:0], shift_q[6:2]};
        if (held_cmd[7]) begin
          shift_q    = pram[ext_addr];
          out_next   = 1'b1;
          xfer_phase = PH_CMD;
        end else begin
          xfer_phase = PH_EXT_DATA;
        end
      end
      default: begin
        if (!wp_flag) pram[ext_addr] = shift_q;
        xfer_phase = PH_CMD;
      end
    endcase
  endtask

  // Advance the shadow state by one request and form its result
  task automatic advance(input logic [1:0] kind, input logic dis, input logic din,
                         input logic [31:0] delta, output srtc_result_t res);
    res = '0;
    case (kind)
      KindEdge: begin
        if (!dis) begin
          out_now = out_next;
          bit_cnt = bit_cnt - 3'd1;
          if (out_now) begin
            res.drives_line = 1'b1;
            res.data_bit    = shift_q[bit_cnt];
            if (bit_cnt == 3'd0) out_next = 1'b0;
          end else begin
            shift_q = {shift_q[6:0], din};
            if (bit_cnt == 3'd0) finish_byte();
          end
        end
      end
      KindSelect: begin
        if (dis) begin
          xfer_phase = PH_CMD;
          out_now    = 1'b0;
          out_next   = 1'b0;
          shift_q    = 8'd0;
          bit_cnt    = 3'd0;
        end
      end
      KindTick: begin
        secs = secs + delta;
      end
      default: ;
    endcase
    res.write_protected = wp_flag;
    res.seconds_count   = secs;
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    srtc_result_t got;
    srtc_result_t want;
    if (!rst_ni) begin
      shift_q    = 8'd0;
      bit_cnt    = 3'd0;
      xfer_phase = PH_CMD;
      held_cmd   = 8'd0;
      ext_addr   = 8'd0;
      wp_flag    = 1'b0;
      out_now    = 1'b0;
      out_next   = 1'b0;
      secs       = 32'd0;
      for (int i = 0; i < PramBytes; i++) pram[i] = 8'd0;
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got = srtc_result_t'(rsp_data_i[34:0]);
        if (owed_results.size() == 0) begin
          report($sformatf("result 0x%0h with no request waiting", rsp_data_i));
        end else begin
          want = owed_results.pop_front();
          check_field("drives_line", got.drives_line, want.drives_line);
          check_field("data_bit", got.data_bit, want.data_bit);
          check_field("write_protected", got.write_protected, want.write_protected);
          check_field("seconds_count", got.seconds_count, want.seconds_count);
        end
      end
      if (req_valid_i && req_ready_i) begin
        advance(req_user_i, req_data_i[0], req_data_i[1], req_data_i[33:2], want);
        owed_results.push_back(want);
      end
      pending_o <= owed_results.size();
    end
  end

  // Anything still owed at the end is lost
  always @(posedge flush_i) begin
    if (owed_results.size() != 0)
      report($sformatf("%0d expected results never arrived", owed_results.size()));
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the serial clock with parameter RAM.
module tb_top;
  import srtc_pkg::*;

  localparam int         ItemTarget  = 1550;
  localparam int         CalmFrom    = 1350;
  localparam int         HoldAt      = 600;
  localparam int         HoldLen     = 300;
  localparam int         NoCut       = 1000;
  localparam logic [7:0] CmdReadSec0 = 8'h80;  // read seconds byte 0

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        flush    = 1'b0;
  int          fail_count;
  int          pending;

  int          items_sent = 0;
  int          edges_left = NoCut;
  bit          calm       = 1'b0;
  logic [7:0]  addr_pool [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  serial_rtc_with_param_ram uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  srtc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (s_tvalid),
    .req_ready_i  (s_tready),
    .req_data_i   (s_tdata),
    .req_user_i   (s_tuser),
    .rsp_valid_i  (m_tvalid),
    .rsp_ready_i  (m_tready),
    .rsp_data_i   (m_tdata),
    .flush_i      (flush),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one request, with an occasional idle burst first; return once accepted
  task automatic drive_item(input logic [1:0] kind, input logic dis, input logic din,
                            input logic [31:0] delta);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'd0, delta, din, dis};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // One serial clock edge; ticks and deselected edges get mixed in now and then
  task automatic edge_bit(input logic b);
    if (edges_left == 0) return;
    edges_left--;
    if ($urandom_range(0, 15) == 0)
      drive_item(KindTick, 1'($urandom), 1'($urandom),
                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3));
    if ($urandom_range(0, 39) == 0) drive_item(KindEdge, 1'b1, 1'($urandom), $urandom);
    drive_item(KindEdge, 1'b0, b, $urandom);
  endtask

  task automatic shift_in_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) edge_bit(b[i]);
  endtask

  task automatic clock_out_byte();
    repeat (8) edge_bit(1'($urandom));
  endtask

  // Select the chip and run one command, sometimes cut short
  task automatic run_transfer();
    logic [7:0] wdata;
    logic [7:0] addr;
    logic [4:0] tgt;
    logic       rd;
    int         pick;
    rd    = 1'($urandom);
    pick  = $urandom_range(0, 3);
    wdata = 8'($urandom);
    drive_item(KindSelect, 1'b1, 1'($urandom), $urandom);
    drive_item(KindSelect, 1'b0, 1'($urandom), $urandom);
    edges_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : NoCut;
    if (pick == 0) begin
      // extended access, often to one of eight pool addresses
      addr = $urandom_range(0, 1) ? addr_pool[$urandom_range(0, 7)] : 8'($urandom);
      shift_in_byte(ExtMatch | {rd, 4'd0, addr[7:5]});
      shift_in_byte({1'($urandom), addr[4:0], 2'($urandom)});
    end else begin
      tgt = (pick == 1) ? 5'($urandom_range(TTest, TWrProt)) : 5'($urandom);
      if (tgt == TWrProt) wdata[7] = ($urandom_range(0, 2) == 0);
      shift_in_byte({rd, tgt, 2'($urandom)});
    end
    if (rd) clock_out_byte();
    else shift_in_byte(wdata);
  endtask

  // Receiver: random stall bursts plus one long hold-off
  initial begin
    int loops;
    loops = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      loops++;
      if (loops == HoldAt) begin
        m_tready <= 1'b0;
        repeat (HoldLen) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Stimulus and verdict
  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (addr_pool[i]) addr_pool[i] = 8'($urandom);

    // seconds wrap, deselect, ignored edge, then a seconds read
    drive_item(KindTick, 1'b0, 1'b0, 32'hFFFF_FFFF);
    drive_item(KindTick, 1'b1, 1'b1, 32'd2);
    drive_item(KindTick, 1'b0, 1'b1, 32'd0);
    drive_item(KindSelect, 1'b1, 1'b0, 32'd0);
    drive_item(KindSelect, 1'b0, 1'b1, 32'hFFFF_FFFF);
    drive_item(KindEdge, 1'b1, 1'b1, 32'hFFFF_FFFF);
    shift_in_byte(CmdReadSec0);
    clock_out_byte();

    // mostly complete transfers, some loose noise
    while (items_sent < ItemTarget) begin
      if (items_sent >= CalmFrom) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4))
          drive_item(2'($urandom_range(KindEdge, KindTick)), 1'($urandom),
                     1'($urandom), $urandom);
      end else begin
        run_transfer();
      end
    end
    s_tvalid <= 1'b0;

    // drain, settle, then close out
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    flush <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
